[hw/rtl/two_operand_decimal_calculator_macros.svh]
// assertion macros used by the top level of the decimal calculator
`ifndef TWO_OPERAND_DECIMAL_CALCULATOR_MACROS_SVH
`define TWO_OPERAND_DECIMAL_CALCULATOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define TODC_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("todc assertion failed");

// next-cycle implication, checked out of reset
`define TODC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("todc assertion failed");

`endif

[hw/rtl/todc_pkg.sv]
// types, codes and helper functions of the decimal calculator
package todc_pkg;

  localparam int VALUE_BITS = 32;
  localparam int CNT_W      = $clog2(VALUE_BITS);

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BAD_OP   = 2'd1;
  localparam logic [1:0] STAT_DIV_ZERO = 2'd2;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef enum logic [2:0] {
    ST_FIRST,
    ST_SECOND,
    ST_DONE,
    ST_DIV,
    ST_CALC,
    ST_BADOP
  } todc_state_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic acc_first;
    logic acc_second;
    logic hold_op;
    logic div_start;
    logic div_step;
    logic load_out;
    logic bad_op;
  } todc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_digit;
    logic is_op;
    logic op_div;
    logic b_zero;
  } todc_stat_t;

  // sign-extend or cut a value to the 32-bit output fields
  function automatic logic [31:0] to_out32(input logic [VALUE_BITS-1:0] x);
    logic signed [VALUE_BITS-1:0] sx;
    sx = signed'(x);
    return 32'(sx);
  endfunction

  function automatic logic is_op_char(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
  endfunction

  function automatic logic [1:0] op_code_of(input logic [7:0] c);
    logic [1:0] code;
    case (c)
      CH_PLUS:  code = OP_ADD;
      CH_MINUS: code = OP_SUB;
      CH_STAR:  code = OP_MUL;
      CH_SLASH: code = OP_DIV;
      default:  code = OP_ADD;
    endcase
    return code;
  endfunction

endpackage

[hw/rtl/todc_dp.sv]
// datapath: accumulators, operator, shift-subtract divider and result register
module todc_dp (
  input  logic                     clk,
  input  logic [7:0]               in_byte,
  input  todc_pkg::todc_cmd_t      cmd,
  output todc_pkg::todc_stat_t     stat,
  output logic signed [31:0]       out_value,
  output logic [1:0]               out_status,
  output logic signed [31:0]       out_first_operand,
  output logic signed [31:0]       out_second_operand,
  output logic [1:0]               out_op_code
);

  localparam int VB = todc_pkg::VALUE_BITS;

  logic [VB-1:0] first_r, first_nxt, second_r, second_nxt;
  logic [VB-1:0] base_first, base_second, digit_val;
  logic [1:0]    op_r, op_nxt;
  logic [VB-1:0] rem_r, quo_r, dvs_r;
  logic          neg_r;
  logic [VB:0]   rs, diff;
  logic          fit;
  logic [VB-1:0] mag_a, mag_b, quot, res;
  logic [1:0]    status;

  logic signed [31:0] out_value_r, out_first_r, out_second_r;
  logic [1:0]         out_status_r, out_op_r;

  // byte classification
  assign stat.is_digit = (in_byte >= todc_pkg::CH_ZERO) && (in_byte <= todc_pkg::CH_NINE);
  assign stat.is_op    = todc_pkg::is_op_char(in_byte);
  assign stat.op_div   = (op_r == todc_pkg::OP_DIV);
  assign stat.b_zero   = (second_r == '0);

  // accumulate: acc * 10 + digit, as two shifts and adds
  assign digit_val   = {{(VB-4){1'b0}}, in_byte[3:0]};
  assign base_first  = cmd.clear ? '0 : first_r;
  assign base_second = cmd.clear ? '0 : second_r;

  always_comb begin
    first_nxt  = base_first;
    second_nxt = base_second;
    op_nxt     = cmd.clear ? todc_pkg::OP_ADD : op_r;
    if (cmd.acc_first) begin
      first_nxt = (base_first << 3) + (base_first << 1) + digit_val;
    end
    if (cmd.acc_second) begin
      second_nxt = (base_second << 3) + (base_second << 1) + digit_val;
    end
    if (cmd.hold_op) begin
      op_nxt = todc_pkg::op_code_of(in_byte);
    end
  end

  always_ff @(posedge clk) begin
    first_r  <= first_nxt;
    second_r <= second_nxt;
    op_r     <= op_nxt;
  end

  // restoring divider on magnitudes, one quotient bit a cycle
  assign mag_a = first_r[VB-1]  ? (VB'(0) - first_r)  : first_r;
  assign mag_b = second_r[VB-1] ? (VB'(0) - second_r) : second_r;
  assign rs    = {rem_r, quo_r[VB-1]};
  assign diff  = rs - {1'b0, dvs_r};
  assign fit   = ~diff[VB];

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= '0;
      quo_r <= mag_a;
      dvs_r <= mag_b;
      neg_r <= first_r[VB-1] ^ second_r[VB-1];
    end else if (cmd.div_step) begin
      rem_r <= fit ? diff[VB-1:0] : rs[VB-1:0];
      quo_r <= {quo_r[VB-2:0], fit};
    end
  end

  assign quot = neg_r ? (VB'(0) - quo_r) : quo_r;

  always_comb begin
    case (op_r)
      todc_pkg::OP_ADD: res = first_r + second_r;
      todc_pkg::OP_SUB: res = first_r - second_r;
      todc_pkg::OP_MUL: res = first_r * second_r;
      todc_pkg::OP_DIV: res = quot;
      default:          res = '0;
    endcase
    if (cmd.bad_op) begin
      status = todc_pkg::STAT_BAD_OP;
    end else if (stat.op_div && stat.b_zero) begin
      status = todc_pkg::STAT_DIV_ZERO;
    end else begin
      status = todc_pkg::STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_value_r  <= (status == todc_pkg::STAT_OK) ? todc_pkg::to_out32(res) : '0;
      out_status_r <= status;
      out_first_r  <= todc_pkg::to_out32(first_r);
      out_second_r <= todc_pkg::to_out32(second_r);
      out_op_r     <= op_r;
    end
  end

  assign out_value          = out_value_r;
  assign out_status         = out_status_r;
  assign out_first_operand  = out_first_r;
  assign out_second_operand = out_second_r;
  assign out_op_code        = out_op_r;

endmodule

[hw/rtl/todc_ctrl.sv]
// controller: parse phases, divider sequencing and result handshake
module todc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_start_req,
  input  logic                  out_ready,
  input  todc_pkg::todc_stat_t  stat,
  output logic                  in_ready,
  output logic                  out_valid,
  output todc_pkg::todc_cmd_t   cmd
);

  localparam int CW = todc_pkg::CNT_W;

  todc_pkg::todc_state_t state_r, state_nxt, phase;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  accept, out_free, last_step;

  assign accept    = in_valid & in_ready;
  assign out_free  = ~out_valid_r | out_ready;
  assign last_step = (cnt_r == CW'(todc_pkg::VALUE_BITS - 1));
  assign phase     = in_start_req ? todc_pkg::ST_FIRST : state_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = '0;
    case (state_r)
      todc_pkg::ST_FIRST, todc_pkg::ST_SECOND, todc_pkg::ST_DONE: begin
        if (accept) begin
          case (phase)
            todc_pkg::ST_FIRST: begin
              if (stat.is_digit) begin
                state_nxt = todc_pkg::ST_FIRST;
              end else if (stat.is_op) begin
                state_nxt = todc_pkg::ST_SECOND;
              end else begin
                state_nxt = todc_pkg::ST_BADOP;
              end
            end
            todc_pkg::ST_SECOND: begin
              if (stat.is_digit) begin
                state_nxt = todc_pkg::ST_SECOND;
              end else if (stat.op_div && !stat.b_zero) begin
                state_nxt = todc_pkg::ST_DIV;
              end else begin
                state_nxt = todc_pkg::ST_CALC;
              end
            end
            default: state_nxt = todc_pkg::ST_DONE;
          endcase
        end
      end
      todc_pkg::ST_DIV: begin
        if (last_step) begin
          state_nxt = todc_pkg::ST_CALC;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      todc_pkg::ST_CALC, todc_pkg::ST_BADOP: begin
        if (out_free) begin
          state_nxt = todc_pkg::ST_DONE;
        end
      end
      default: state_nxt = todc_pkg::ST_DONE;
    endcase
  end

  // outputs and commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      todc_pkg::ST_FIRST, todc_pkg::ST_SECOND, todc_pkg::ST_DONE: begin
        in_ready = 1'b1;
      end
      todc_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      todc_pkg::ST_CALC: begin
        cmd.load_out = out_free;
      end
      todc_pkg::ST_BADOP: begin
        cmd.load_out = out_free;
        cmd.bad_op   = 1'b1;
      end
      default: in_ready = 1'b0;
    endcase
    cmd.clear      = accept & in_start_req;
    cmd.acc_first  = accept & (phase == todc_pkg::ST_FIRST) & stat.is_digit;
    cmd.hold_op    = accept & (phase == todc_pkg::ST_FIRST) & ~stat.is_digit & stat.is_op;
    cmd.acc_second = accept & (phase == todc_pkg::ST_SECOND) & stat.is_digit;
    cmd.div_start  = accept & (phase == todc_pkg::ST_SECOND) & ~stat.is_digit &
                     stat.op_div & ~stat.b_zero;
  end

  assign out_valid_nxt = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= todc_pkg::ST_DONE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hw/rtl/two_operand_decimal_calculator.sv]
// top level of the two-operand decimal calculator
// usage:
//   input channel (in_valid/in_ready) carries one ascii byte per transaction;
//   in_start_req marks the first byte of a formula such as 12+34 and clears
//   the parse state. digits build the first number, one of + - * / follows,
//   digits build the second number, and the first non-digit after it ends
//   the formula. bytes outside a formula are taken and dropped.
//   result channel (out_valid/out_ready) carries one transaction per formula:
//   value, status, both operands and the operator code.
// throughput and sequencing:
//   digits and the operator byte are taken one per cycle. after the ending
//   byte, + - * and errors go straight to loading the result, while a
//   divide first runs the one-bit-per-cycle shift-subtract divider;
//   in_ready is low meanwhile. the result is registered and is loaded
//   into the output register once that register is free.
// stalls and reset:
//   a pending result sits in the output register; further bytes are still
//   taken up to the next ending byte, then in_ready stays low until out_ready.
//   synchronous active-low reset leaves the block idle, waiting for a start.
`include "two_operand_decimal_calculator_macros.svh"

module two_operand_decimal_calculator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               in_start_req,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_value,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_first_operand,
  output logic signed [31:0] out_second_operand,
  output logic [1:0]         out_op_code
);

  todc_pkg::todc_cmd_t  cmd;   // controller commands
  todc_pkg::todc_stat_t stat;  // byte class and operand flags

  // operand registers, divider and result register
  todc_dp u_dp (
    .clk                (clk),
    .in_byte            (in_byte),
    .cmd                (cmd),
    .stat               (stat),
    .out_value          (out_value),
    .out_status         (out_status),
    .out_first_operand  (out_first_operand),
    .out_second_operand (out_second_operand),
    .out_op_code        (out_op_code)
  );

  // parse state machine and handshakes
  todc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_start_req (in_start_req),
    .out_ready    (out_ready),
    .stat         (stat),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .cmd          (cmd)
  );

  // a new result never overwrites one still waiting
  `TODC_ASSERT_IMPLIES(a_no_overwrite, cmd.load_out, !out_valid || out_ready)
  // no byte is taken while the divider runs or a result is being loaded
  `TODC_ASSERT_IMPLIES(a_busy_no_input, cmd.div_step || cmd.load_out, !in_ready)
  // any error result carries a zero value
  `TODC_ASSERT_IMPLIES(a_err_zero, out_valid && (out_status != todc_pkg::STAT_OK),
                       out_value == 32'sd0)

endmodule
